/* sv/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package pli_pkg;
	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOT_EN  = 2'd1;
	localparam logic [1:0] ST_ZERO_DX = 2'd2;
	localparam logic [1:0] ST_NO_SEG  = 2'd3;

	localparam logic [1:0] HK_LOW    = 2'd0;
	localparam logic [1:0] HK_HIGH   = 2'd1;
	localparam logic [1:0] HK_EXACT  = 2'd2;
	localparam logic [1:0] HK_INTERP = 2'd3;

	localparam logic REG_COUNT  = 1'b0;
	localparam logic REG_ENABLE = 1'b1;

	typedef struct packed {
		logic              is_write;
		logic              enabled;
		logic [IdxW-1:0]   slot;
		logic [IdxW-1:0]   last;
		logic [31:0]       x;
		logic [31:0]       y;
	} cmd_t;
endpackage
`default_nettype wire

/* sv/pli_front.sv */
// ----------------------------------------------------------------------------
// pli_front
// Accepts commands, snapshots configuration, and pushes them to a 2-deep queue.
// ----------------------------------------------------------------------------
`default_nettype none
module pli_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          mode,
	input  wire logic [3:0]    entry_index,
	input  wire logic [31:0]   x_value,
	input  wire logic [31:0]   y_value,
	input  wire logic [4:0]    entry_count,
	input  wire logic          table_enable,
	input  wire logic          pop,
	output logic               full,
	output logic               q_valid,
	output pli_pkg::cmd_t      q_head
);
	import pli_pkg::*;
	cmd_t      buf_q [2];
	logic      rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t      c;
	logic      push;
	logic [CntW-1:0] n;

	assign full = cnt_q == 2'd2;
	assign push = start && !full;
	assign q_valid = cnt_q != 2'd0;
	assign q_head = buf_q[rd_q];

	always_comb begin
		if (entry_count == 5'd0)
			n = CntW'(1);
		else if (32'(entry_count) > TableDepth)
			n = CntW'(TableDepth);
		else
			n = CntW'(entry_count);
		c.is_write = mode;
		c.enabled  = table_enable;
		c.slot     = IdxW'(entry_index);
		c.last     = IdxW'(n - CntW'(1));
		c.x        = x_value;
		c.y        = y_value;
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* sv/pli_div.sv */
// ----------------------------------------------------------------------------
// pli_div
// Restoring 32-bit signed truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pli_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	import pli_pkg::*;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};
	assign quotient = neg_q ? 32'(0) - quo_q : quo_q;

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= 32'd0;
			quo_q <= dividend[31] ? 32'(0) - dividend : dividend;
			dvs_q <= divisor[31] ? 32'(0) - divisor : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 6'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* sv/pli_back.sv */
// ----------------------------------------------------------------------------
// pli_back
// Executes commands: table writes, clamp checks, segment search, interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module pli_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  pli_pkg::cmd_t      q_head,
	output logic               pop,
	output logic               res_valid,
	output logic [31:0]        res_y,
	output logic [1:0]         res_status,
	output logic [1:0]         res_kind
);
	import pli_pkg::*;
	localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_RDL = 4'd2, S_CHK = 4'd3,
		S_SRD = 4'd4, S_SCMP = 4'd5, S_DIV = 4'd6, S_MUL = 4'd7, S_ADD = 4'd8;

	logic [31:0] xmem [TableDepth];
	logic [31:0] ymem [TableDepth];
	logic [31:0] rx_q, ry_q, rx1_q, ry1_q;
	logic [31:0] x0_q, y0_q, prod_q;
	logic [3:0]  st_q;
	logic [IdxW-1:0] ra_q, i_q;
	cmd_t        cmd_q;
	logic        dgo, ddone;
	logic [31:0] quo, dx, dy;

	assign dx = rx1_q - x0_q;
	assign dy = ry1_q - y0_q;

	always_ff @(posedge clk) begin
		if (q_valid && st_q == S_IDLE && q_head.is_write) begin
			xmem[q_head.slot] <= q_head.x;
			ymem[q_head.slot] <= q_head.y;
		end
		rx_q  <= xmem[ra_q];
		ry_q  <= ymem[ra_q];
		rx1_q <= rx_q;
		ry1_q <= ry_q;
	end

	pli_div u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .dividend(dy), .divisor(dx),
		.done(ddone), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (st_q == S_MUL) begin
			x0_q <= rx1_q;
			y0_q <= ry1_q;
		end
		if (ddone)
			prod_q <= quo * (cmd_q.x - x0_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pop <= 1'b0;
			res_valid <= 1'b0;
			res_y <= 32'd0;
			res_status <= ST_OK;
			res_kind <= HK_LOW;
			ra_q <= '0;
			i_q <= '0;
			dgo <= 1'b0;
			cmd_q <= '0;
		end else begin
			pop <= 1'b0;
			res_valid <= 1'b0;
			dgo <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_valid && !pop) begin
						pop <= 1'b1;
						cmd_q <= q_head;
						if (q_head.is_write || !q_head.enabled) begin
							res_valid <= 1'b1;
							res_y <= 32'd0;
							res_status <= q_head.is_write ? ST_OK : ST_NOT_EN;
							res_kind <= HK_LOW;
						end else begin
							ra_q <= '0;
							st_q <= S_RD0;
						end
					end
				end
				S_RD0: begin
					ra_q <= cmd_q.last;
					st_q <= S_RDL;
				end
				S_RDL: st_q <= S_CHK;
				S_CHK: begin
					// rx1_q/ry1_q: entry 0, rx_q/ry_q: last entry
					if ($signed(cmd_q.x) <= $signed(rx1_q)) begin
						res_valid <= 1'b1;
						res_y <= ry1_q;
						res_status <= ST_OK;
						res_kind <= HK_LOW;
						st_q <= S_IDLE;
					end else if ($signed(cmd_q.x) >= $signed(rx_q)) begin
						res_valid <= 1'b1;
						res_y <= ry_q;
						res_status <= ST_OK;
						res_kind <= HK_HIGH;
						st_q <= S_IDLE;
					end else begin
						i_q <= '0;
						ra_q <= '0;
						st_q <= S_SRD;
					end
				end
				S_SRD: begin
					ra_q <= i_q + IdxW'(1);
					st_q <= S_SCMP;
				end
				S_SCMP: st_q <= S_MUL;
				S_MUL: begin
					// rx1_q = X[i], rx_q = X[i+1]
					if (cmd_q.x == rx1_q) begin
						res_valid <= 1'b1;
						res_y <= ry1_q;
						res_status <= ST_OK;
						res_kind <= HK_EXACT;
						st_q <= S_IDLE;
					end else if ($signed(cmd_q.x) > $signed(rx1_q)
						&& $signed(cmd_q.x) < $signed(rx_q)) begin
						if (rx_q == rx1_q) begin
							res_valid <= 1'b1;
							res_y <= 32'd0;
							res_status <= ST_ZERO_DX;
							res_kind <= HK_INTERP;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_DIV;
							dgo <= 1'b1;
						end
					end else if (i_q + IdxW'(1) >= cmd_q.last) begin
						res_valid <= 1'b1;
						res_y <= 32'd0;
						res_status <= ST_NO_SEG;
						res_kind <= HK_LOW;
						st_q <= S_IDLE;
					end else begin
						i_q <= i_q + IdxW'(1);
						ra_q <= i_q + IdxW'(1);
						st_q <= S_SRD;
					end
				end
				S_DIV: begin
					if (ddone)
						st_q <= S_ADD;
				end
				S_ADD: begin
					res_valid <= 1'b1;
					res_y <= y0_q + prod_q;
					res_status <= ST_OK;
					res_kind <= HK_INTERP;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/piecewise_linear_interpolator_core.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Breakpoint table with clamp, exact hit and linear interpolation.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; commands queue two
// deep in front of the execution unit and busy is high while the queue is full.
// Writes and disabled lookups are answered from the idle state; a lookup first
// reads entry 0 and the last entry for the clamp checks, then one segment per
// search step, and then runs the serial divider and the final add. Each result
// appears for one cycle with done; the receiver cannot stall.
`default_nettype none
module piecewise_linear_interpolator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [3:0]  entry_index,
	input  wire logic [31:0] x_value,
	input  wire logic [31:0] y_value,
	output logic             done,
	output logic [31:0]      y_result,
	output logic [1:0]       status,
	output logic [1:0]       hit_kind,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pli_pkg::*;
	logic [4:0] count_q;
	logic       enable_q;
	logic       q_valid, pop;
	cmd_t       head;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			REG_COUNT:  prdata = {27'd0, count_q};
			REG_ENABLE: prdata = {31'd0, enable_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd2;
			enable_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_COUNT)
				count_q <= pwdata[4:0];
			else
				enable_q <= pwdata[0];
		end
	end

	pli_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode),
		.entry_index(entry_index), .x_value(x_value), .y_value(y_value),
		.entry_count(count_q), .table_enable(enable_q), .pop(pop),
		.full(busy), .q_valid(q_valid), .q_head(head)
	);

	pli_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(head), .pop(pop),
		.res_valid(done), .res_y(y_result), .res_status(status), .res_kind(hit_kind)
	);

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $past(q_valid)) else $error("pop from empty queue");
	a_pop_single: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop) else $error("pop on consecutive cycles");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> y_result == 32'd0) else $error("error with value");
endmodule
`default_nettype wire
